// ===== design/mcc_pkg.sv =====
package mcc_pkg;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;

   localparam logic [1:0] KIND_PLAIN   = 2'd0;
   localparam logic [1:0] KIND_COMMENT = 2'd1;
   localparam logic [1:0] KIND_TAG     = 2'd2;
   localparam logic [1:0] KIND_HEADER  = 2'd3;

   localparam int unsigned MAX_RES = 4;
   localparam int unsigned HOLD_DEPTH = 3;

   typedef struct packed {
      logic [7:0] ch;
      logic [1:0] kind;
      logic       start;
      logic       last;
   } res_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

endpackage

// ===== design/markup_char_classifier.sv =====
// Channel  Dir  Handshake            Beat
// req      in   req_valid/req_ready  req_char_code, req_last_in
// rsp      out  rsp_valid/rsp_ready  rsp_out_char, rsp_char_kind, rsp_span_start, rsp_last_out
//
// An accepted character is classified in the accept cycle; its 0 to 4 results land in a
// four-entry result buffer that drains one beat per cycle while rsp_ready is high. A
// character that yields k results holds req_ready low until k-1 of them have drained, so
// plain text streams at one character per cycle while rsp_ready is high. Synchronous
// active-high reset empties the buffer and returns the scanner to plain mode at line start. A
// stall on rsp only blocks req once the buffer holds more than the beat leaving in that cycle.
module markup_char_classifier (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_last_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic [1:0] rsp_char_kind,
   output logic       rsp_span_start,
   output logic       rsp_last_out
);
   import mcc_pkg::*;

   typedef enum logic [2:0] {
      MODE_PLAIN   = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_TAG     = 3'd2,
      MODE_QUOTE   = 3'd3,
      MODE_HEADER  = 3'd4
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [7:0] hb_ff [HOLD_DEPTH];
   logic [7:0] hb_in [HOLD_DEPTH];
   logic       qd_ff, qd_in;
   logic [1:0] dash_ff, dash_in;
   logic       als_ff, als_in;

   res_type    buf_ff [MAX_RES];
   res_type    res [MAX_RES];
   logic [2:0] rcnt_ff;
   logic [2:0] n;

   logic       accept, pop;
   logic       do_fresh, do_release;
   logic [7:0] c;

   assign c         = req_char_code;
   assign rsp_valid = (rcnt_ff != 3'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (rcnt_ff == 3'd0) || ((rcnt_ff == 3'd1) && rsp_ready);
   assign accept    = req_valid && req_ready;

   assign rsp_out_char   = buf_ff[0].ch;
   assign rsp_char_kind  = buf_ff[0].kind;
   assign rsp_span_start = buf_ff[0].start;
   assign rsp_last_out   = buf_ff[0].last;

   always_comb begin
      res        = '{default: '0};
      n          = 3'd0;
      mode_in    = mode_ff;
      cnt_in     = cnt_ff;
      hb_in      = hb_ff;
      qd_in      = qd_ff;
      dash_in    = dash_ff;
      als_in     = (c == CH_NL);
      do_fresh   = 1'b0;
      do_release = 1'b0;

      unique case (mode_ff)
         MODE_COMMENT: begin
            res[0] = '{c, KIND_COMMENT, 1'b0, 1'b0};
            n = 3'd1;
            if (c == CH_DASH) begin
               if (dash_ff < 2'd2) dash_in = dash_ff + 2'd1;
            end else if (c == CH_GT && dash_ff == 2'd2) begin
               mode_in = MODE_PLAIN;
               dash_in = 2'd0;
            end else begin
               dash_in = 2'd0;
            end
         end
         MODE_TAG, MODE_QUOTE: begin
            n = 3'd1;
            if (c == CH_NL) begin
               mode_in = MODE_PLAIN;
               res[0]  = '{c, KIND_PLAIN, 1'b0, 1'b0};
            end else begin
               res[0] = '{c, KIND_TAG, 1'b0, 1'b0};
               if (mode_ff == MODE_QUOTE) begin
                  if (c == (qd_ff ? CH_DQ : CH_SQ)) mode_in = MODE_TAG;
               end else if (c == CH_GT) begin
                  mode_in = MODE_PLAIN;
               end else if (c == CH_DQ || c == CH_SQ) begin
                  mode_in = MODE_QUOTE;
                  qd_in   = (c == CH_DQ);
               end
            end
         end
         MODE_HEADER: begin
            n = 3'd1;
            if (c == CH_NL) begin
               mode_in = MODE_PLAIN;
               res[0]  = '{c, KIND_PLAIN, 1'b0, 1'b0};
            end else begin
               res[0] = '{c, KIND_HEADER, 1'b0, 1'b0};
            end
         end
         default: begin
            mode_in = MODE_PLAIN;
            unique case (cnt_ff)
               2'd0: do_fresh = 1'b1;
               2'd1: begin
                  if (is_letter(c) || c == CH_SLASH) begin
                     res[0]  = '{hb_ff[0], KIND_TAG, 1'b1, 1'b0};
                     res[1]  = '{c, KIND_TAG, 1'b0, 1'b0};
                     n       = 3'd2;
                     cnt_in  = 2'd0;
                     mode_in = MODE_TAG;
                  end else if (c == CH_BANG) begin
                     hb_in[1] = c;
                     cnt_in   = 2'd2;
                  end else begin
                     do_release = 1'b1;
                     do_fresh   = 1'b1;
                  end
               end
               2'd2: begin
                  if (c == CH_DASH) begin
                     hb_in[2] = c;
                     cnt_in   = 2'd3;
                  end else begin
                     do_release = 1'b1;
                     do_fresh   = 1'b1;
                  end
               end
               default: begin
                  if (c == CH_DASH) begin
                     res[0]  = '{hb_ff[0], KIND_COMMENT, 1'b1, 1'b0};
                     res[1]  = '{hb_ff[1], KIND_COMMENT, 1'b0, 1'b0};
                     res[2]  = '{hb_ff[2], KIND_COMMENT, 1'b0, 1'b0};
                     res[3]  = '{c, KIND_COMMENT, 1'b0, 1'b0};
                     n       = 3'd4;
                     cnt_in  = 2'd0;
                     mode_in = MODE_COMMENT;
                     dash_in = 2'd0;
                  end else begin
                     do_release = 1'b1;
                     do_fresh   = 1'b1;
                  end
               end
            endcase
         end
      endcase

      // held '<' run turned out plain: flush it ahead of this character
      if (do_release) begin
         for (int k = 0; k < HOLD_DEPTH; k++) begin
            if (k < int'(cnt_ff)) res[k] = '{hb_ff[k], KIND_PLAIN, 1'b0, 1'b0};
         end
         n      = {1'b0, cnt_ff};
         cnt_in = 2'd0;
      end

      if (do_fresh) begin
         if (c == CH_LT) begin
            hb_in[0] = c;
            cnt_in   = 2'd1;
         end else if (c == CH_HASH && als_ff) begin
            res[n[1:0]] = '{c, KIND_HEADER, 1'b1, 1'b0};
            n           = n + 3'd1;
            mode_in     = MODE_HEADER;
         end else begin
            res[n[1:0]] = '{c, KIND_PLAIN, 1'b0, 1'b0};
            n           = n + 3'd1;
         end
      end

      if (req_last_in) begin
         for (int k = 0; k < HOLD_DEPTH; k++) begin
            if (k < int'(cnt_in) && n < 3'(MAX_RES)) begin
               res[n[1:0]] = '{hb_in[k], KIND_PLAIN, 1'b0, 1'b0};
               n           = n + 3'd1;
            end
         end
         if (n != 3'd0) res[n[1:0] - 2'd1].last = 1'b1;
         mode_in = MODE_PLAIN;
         cnt_in  = 2'd0;
         qd_in   = 1'b0;
         dash_in = 2'd0;
         als_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         cnt_ff  <= 2'd0;
         qd_ff   <= 1'b0;
         dash_ff <= 2'd0;
         als_ff  <= 1'b1;
         rcnt_ff <= 3'd0;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
            cnt_ff  <= cnt_in;
            qd_ff   <= qd_in;
            dash_ff <= dash_in;
            als_ff  <= als_in;
            rcnt_ff <= n;
         end else if (pop) begin
            rcnt_ff <= rcnt_ff - 3'd1;
         end
      end
      if (accept) begin
         hb_ff  <= hb_in;
         buf_ff <= res;
      end else if (pop) begin
         for (int k = 0; k < MAX_RES - 1; k++) buf_ff[k] <= buf_ff[k + 1];
      end
   end

`ifndef NO_ASSERTIONS
   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_in |=> cnt_ff == 2'd0 && mode_ff == MODE_PLAIN && als_ff)
      else $error("scanner state not cleared after last character");

   a_last_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_out |-> rcnt_ff == 3'd1)
      else $error("last beat is not the final buffered result");

   a_hold_plain: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd0 |-> mode_ff == MODE_PLAIN)
      else $error("lookahead held outside plain mode");
`endif

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mcc_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 200000;
   localparam int unsigned HOLD_CYCLES  = 300;

   typedef enum logic [2:0] {
      SM_PLAIN,
      SM_COMMENT,
      SM_TAG,
      SM_QUOTE,
      SM_HEADER
   } scan_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_code = 8'h00;
   logic       req_last_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_char;
   logic [1:0] rsp_char_kind;
   logic       rsp_span_start;
   logic       rsp_last_out;

   markup_char_classifier u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_code  (req_char_code),
      .req_last_in    (req_last_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_char_kind  (rsp_char_kind),
      .rsp_span_start (rsp_span_start),
      .rsp_last_out   (rsp_last_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus and expectations
   char_beat_type pend_chars[$];
   res_type       exp_beats[$];
   char_beat_type drv_beat;
   res_type       got_beat;
   res_type       want_beat;

   int unsigned n_queued = 0;
   int unsigned n_acc = 0;
   int unsigned n_checked = 0;
   int unsigned n_texts = 0;
   int unsigned n_spans = 0;
   int unsigned errors = 0;
   int unsigned cycles = 0;
   int unsigned req_idle = 0;
   int unsigned rsp_stall = 0;
   bit          req_fire = 1'b0;
   bit          hold_req = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned hold_left = 0;
   logic        hold_on;

   // scanner copy
   logic [7:0]  held [3];
   int unsigned held_cnt = 0;
   scan_type    mode = SM_PLAIN;
   logic        quote_dq = 1'b0;
   int unsigned dash_cnt = 0;
   logic        line_start = 1'b1;
   int unsigned step_n = 0;

   function automatic logic ascii_alpha(input logic [7:0] c);
      return (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
   endfunction

   task automatic put_res(input logic [7:0] c, input logic [1:0] k, input logic s);
      res_type r;
      if (step_n < MAX_RES) begin
         r.ch = c;
         r.kind = k;
         r.start = s;
         r.last = 1'b0;
         exp_beats.push_back(r);
         step_n++;
      end
   endtask

   task automatic flush_held();
      for (int unsigned k = 0; k < held_cnt && k < HOLD_DEPTH; k++)
         put_res(held[k], KIND_PLAIN, 1'b0);
      held_cnt = 0;
   endtask

   task automatic fresh_plain(input logic [7:0] c);
      if (c == CH_LT) begin
         held[0] = c;
         held_cnt = 1;
      end else if (c == CH_HASH && line_start) begin
         put_res(c, KIND_HEADER, 1'b1);
         mode = SM_HEADER;
      end else begin
         put_res(c, KIND_PLAIN, 1'b0);
      end
   endtask

   task automatic step_char(input logic [7:0] c, input logic last);
      int unsigned n0;
      n0 = exp_beats.size();
      step_n = 0;
      case (mode)
         SM_COMMENT: begin
            put_res(c, KIND_COMMENT, 1'b0);
            if (c == CH_DASH) begin
               if (dash_cnt < 2) dash_cnt++;
            end else if (c == CH_GT && dash_cnt >= 2) begin
               mode = SM_PLAIN;
               dash_cnt = 0;
            end else begin
               dash_cnt = 0;
            end
         end
         SM_TAG: begin
            if (c == CH_NL) begin
               mode = SM_PLAIN;
               put_res(c, KIND_PLAIN, 1'b0);
            end else begin
               put_res(c, KIND_TAG, 1'b0);
               if (c == CH_GT) begin
                  mode = SM_PLAIN;
               end else if (c == CH_DQ || c == CH_SQ) begin
                  mode = SM_QUOTE;
                  quote_dq = (c == CH_DQ);
               end
            end
         end
         SM_QUOTE: begin
            if (c == CH_NL) begin
               mode = SM_PLAIN;
               put_res(c, KIND_PLAIN, 1'b0);
            end else begin
               put_res(c, KIND_TAG, 1'b0);
               if (c == (quote_dq ? CH_DQ : CH_SQ)) mode = SM_TAG;
            end
         end
         SM_HEADER: begin
            if (c == CH_NL) begin
               mode = SM_PLAIN;
               put_res(c, KIND_PLAIN, 1'b0);
            end else begin
               put_res(c, KIND_HEADER, 1'b0);
            end
         end
         default: begin
            mode = SM_PLAIN;
            case (held_cnt)
               0: fresh_plain(c);
               1: begin
                  if (ascii_alpha(c) || c == CH_SLASH) begin
                     put_res(held[0], KIND_TAG, 1'b1);
                     put_res(c, KIND_TAG, 1'b0);
                     held_cnt = 0;
                     mode = SM_TAG;
                  end else if (c == CH_BANG) begin
                     held[1] = c;
                     held_cnt = 2;
                  end else begin
                     flush_held();
                     fresh_plain(c);
                  end
               end
               2: begin
                  if (c == CH_DASH) begin
                     held[2] = c;
                     held_cnt = 3;
                  end else begin
                     flush_held();
                     fresh_plain(c);
                  end
               end
               default: begin
                  if (c == CH_DASH) begin
                     put_res(held[0], KIND_COMMENT, 1'b1);
                     put_res(held[1], KIND_COMMENT, 1'b0);
                     put_res(held[2], KIND_COMMENT, 1'b0);
                     put_res(c, KIND_COMMENT, 1'b0);
                     held_cnt = 0;
                     mode = SM_COMMENT;
                     dash_cnt = 0;
                  end else begin
                     flush_held();
                     fresh_plain(c);
                  end
               end
            endcase
         end
      endcase
      if (last) begin
         flush_held();
         if (exp_beats.size() > n0) exp_beats[exp_beats.size() - 1].last = 1'b1;
         held_cnt = 0;
         mode = SM_PLAIN;
         quote_dq = 1'b0;
         dash_cnt = 0;
         line_start = 1'b1;
      end else begin
         line_start = (c == CH_NL);
      end
   endtask

   // sender: a beat stays up until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pend_chars.size() != 0 && $urandom_range(99) >= req_idle) begin
            drv_beat = pend_chars.pop_front();
            req_valid <= 1'b1;
            req_char_code <= drv_beat.ch;
            req_last_in <= drv_beat.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      rsp_ready <= !hold_on && ($urandom_range(99) >= rsp_stall);
   end

   // long back-pressure window, counted here
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end
   assign hold_on = (hold_left != 0);

   always @(posedge clock) begin
      req_fire = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_fire = 1'b1;
            step_char(req_char_code, req_last_in);
            n_acc++;
            if (req_last_in) n_texts++;
         end
         if (rsp_valid && rsp_ready) begin
            got_beat.ch = rsp_out_char;
            got_beat.kind = rsp_char_kind;
            got_beat.start = rsp_span_start;
            got_beat.last = rsp_last_out;
            n_checked++;
            if (rsp_span_start) n_spans++;
            if (exp_beats.size() == 0) begin
               $display("%0t: unexpected beat char=%h kind=%0d start=%b last=%b", $time,
                        got_beat.ch, got_beat.kind, got_beat.start, got_beat.last);
               errors++;
            end else begin
               want_beat = exp_beats.pop_front();
               if (got_beat.ch !== want_beat.ch) begin
                  $display("%0t: out_char expected %h actual %h", $time,
                           want_beat.ch, got_beat.ch);
                  errors++;
               end
               if (got_beat.kind !== want_beat.kind) begin
                  $display("%0t: char_kind expected %0d actual %0d (char %h)", $time,
                           want_beat.kind, got_beat.kind, want_beat.ch);
                  errors++;
               end
               if (got_beat.start !== want_beat.start) begin
                  $display("%0t: span_start expected %b actual %b (char %h)", $time,
                           want_beat.start, got_beat.start, want_beat.ch);
                  errors++;
               end
               if (got_beat.last !== want_beat.last) begin
                  $display("%0t: last_out expected %b actual %b (char %h)", $time,
                           want_beat.last, got_beat.last, want_beat.ch);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("%0t: timeout, %0d results still pending", $time, exp_beats.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // text generation
   task automatic add_ch(input logic [7:0] c, input logic last = 1'b0);
      char_beat_type b;
      b.ch = c;
      b.last = last;
      pend_chars.push_back(b);
      n_queued++;
   endtask

   function automatic logic [7:0] pick_letter();
      logic [7:0] base;
      base = $urandom_range(1) ? 8'h41 : 8'h61;
      return base + 8'($urandom_range(25));
   endfunction

   // neighbors of the letter ranges and other non-opening bytes
   function automatic logic [7:0] pick_nonopen();
      case ($urandom_range(7))
         0: return 8'h40;
         1: return 8'h5B;
         2: return 8'h60;
         3: return 8'h7B;
         4: return 8'h20;
         5: return CH_LT;
         6: return CH_HASH;
         default: return 8'hC1;
      endcase
   endfunction

   function automatic logic [7:0] pick_body();
      case ($urandom_range(9))
         0: return CH_DASH;
         1: return CH_GT;
         2: return CH_DQ;
         3: return CH_SQ;
         4: return 8'h20;
         5: return 8'($urandom_range(255));
         default: return pick_letter();
      endcase
   endfunction

   task automatic gen_tag();
      logic [7:0] q;
      add_ch(CH_LT);
      add_ch(($urandom_range(3) == 0) ? CH_SLASH : pick_letter());
      repeat ($urandom_range(4)) add_ch(pick_letter());
      repeat ($urandom_range(2)) begin
         add_ch(8'h20);
         repeat ($urandom_range(1, 3)) add_ch(pick_letter());
         add_ch(8'h3D);
         q = $urandom_range(1) ? CH_DQ : CH_SQ;
         add_ch(q);
         repeat ($urandom_range(5)) begin
            if ($urandom_range(19) == 0) add_ch(CH_NL);
            else add_ch((pick_body() == q) ? CH_GT : pick_body());
         end
         if ($urandom_range(7) != 0) add_ch(q);
      end
      case ($urandom_range(9))
         0: add_ch(CH_NL);
         1: ;
         default: add_ch(CH_GT);
      endcase
   endtask

   task automatic gen_comment();
      add_ch(CH_LT);
      add_ch(CH_BANG);
      add_ch(CH_DASH);
      add_ch(CH_DASH);
      repeat ($urandom_range(8)) begin
         case ($urandom_range(5))
            0, 1: add_ch(CH_DASH);
            2: add_ch(CH_GT);
            3: add_ch(CH_NL);
            default: add_ch(pick_letter());
         endcase
      end
      case ($urandom_range(7))
         0: ;
         1: begin
            add_ch(CH_DASH);
            add_ch(CH_DASH);
            add_ch(CH_DASH);
            add_ch(CH_GT);
         end
         default: begin
            add_ch(CH_DASH);
            add_ch(CH_DASH);
            add_ch(CH_GT);
         end
      endcase
   endtask

   task automatic gen_broken();
      add_ch(CH_LT);
      case ($urandom_range(2))
         0: add_ch(pick_nonopen());
         1: begin
            add_ch(CH_BANG);
            add_ch(($urandom_range(1) == 0) ? pick_letter() : pick_nonopen());
         end
         default: begin
            add_ch(CH_BANG);
            add_ch(CH_DASH);
            add_ch(($urandom_range(1) == 0) ? CH_GT : pick_nonopen());
         end
      endcase
   endtask

   task automatic gen_header();
      if ($urandom_range(3) != 0) add_ch(CH_NL);
      add_ch(CH_HASH);
      repeat ($urandom_range(6)) add_ch(($urandom_range(5) == 0) ? CH_HASH : pick_body());
      if ($urandom_range(3) != 0) add_ch(CH_NL);
   endtask

   task automatic gen_texts(input int unsigned n_items);
      int unsigned target;
      target = n_queued + n_items;
      while (n_queued < target) begin
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(9))
               0, 1: repeat ($urandom_range(1, 6)) add_ch(pick_letter());
               2: add_ch(CH_NL);
               3, 4: gen_tag();
               5: gen_comment();
               6: gen_broken();
               7: gen_header();
               default: add_ch(8'($urandom_range(255)));
            endcase
         end
         // sometimes end the text inside an opener
         case ($urandom_range(5))
            0: add_ch(CH_LT);
            1: begin
               add_ch(CH_LT);
               add_ch(CH_BANG);
            end
            2: begin
               add_ch(CH_LT);
               add_ch(CH_BANG);
               add_ch(CH_DASH);
            end
            default: ;
         endcase
         pend_chars[pend_chars.size() - 1].last = 1'b1;
      end
   endtask

   task automatic run_phase(input int unsigned idle, input int unsigned stall,
                            input int unsigned n_items);
      req_idle = idle;
      rsp_stall = stall;
      gen_texts(n_items);
      while (n_acc != n_queued || exp_beats.size() != 0) @(negedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // header at text start, then a tag whose quoted text holds '>'
      add_ch(CH_HASH);
      add_ch("h");
      add_ch(CH_NL);
      add_ch(CH_LT);
      add_ch("a");
      add_ch(CH_DQ);
      add_ch(CH_GT);
      add_ch(CH_DQ);
      add_ch(CH_GT);
      // dash right after the opener does not count toward the closer
      add_ch(CH_LT);
      add_ch(CH_BANG);
      add_ch(CH_DASH);
      add_ch(CH_DASH);
      add_ch(CH_DASH);
      add_ch(CH_GT);
      add_ch(CH_DASH);
      add_ch(CH_DASH);
      add_ch(CH_GT);
      add_ch(CH_LT);
      add_ch(8'h20);
      add_ch(8'hFF);
      add_ch(8'h00);
      add_ch(CH_LT);
      add_ch(CH_SLASH);
      add_ch(CH_NL);
      // text ends with the opener still held
      add_ch(CH_LT);
      add_ch(CH_BANG);
      add_ch(CH_DASH, 1'b1);

      run_phase(0, 0, 90);
      run_phase(85, 0, 90);
      run_phase(0, 85, 90);
      run_phase(31, 31, 90);
      hold_req = 1'b1;
      run_phase(0, 0, 50);

      repeat (16) @(negedge clock);
      $display("%0d characters in %0d texts, %0d result beats checked (%0d span starts)",
               n_acc, n_texts, n_checked, n_spans);
      $display("phases: free flow, idle sender, stalling receiver, both, long hold-off");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
